### hw/rtl/fwpd_pkg.sv
// ----------------------------------------------------------------------------
// fwpd_pkg
// Shared types and constants of the firmware packet deframer.
// ----------------------------------------------------------------------------
package fwpd_pkg;

  localparam int unsigned FULL_WORDS_DEF = 128;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WRITE_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MARKER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR   = 2'd2;

  localparam logic [BYTE_W-1:0] WRITE_CODE_RST  = 8'd0;
  localparam logic [BYTE_W-1:0] FULL_MARKER_RST = 8'd255;
  localparam logic [ADDR_W-1:0] BASE_ADDR_RST   = 32'd0;

  typedef enum logic [2:0] {
    PH_CMD  = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] write_command_code;
    logic [BYTE_W-1:0] full_length_marker;
    logic [ADDR_W-1:0] flash_base_address;
    logic              base_load;
  } cfg_t;

endpackage

### hw/rtl/fwpd_if.sv
// ----------------------------------------------------------------------------
// fwpd_in_if / fwpd_out_if
// Valid/ready channels for received bytes and for packed flash words.
// ----------------------------------------------------------------------------
interface fwpd_in_if;
  logic                          valid;
  logic                          ready;
  logic [fwpd_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fwpd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          word_valid;
  logic [fwpd_pkg::WORD_W-1:0]   data_word;
  logic [fwpd_pkg::ADDR_W-1:0]   word_address;
  logic                          packet_end;
  logic                          update_done;
  logic                          bad_command;

  modport source (output valid, output word_valid, output data_word, output word_address,
                  output packet_end, output update_done, output bad_command, input ready);
  modport sink   (input valid, input word_valid, input data_word, input word_address,
                  input packet_end, input update_done, input bad_command, output ready);
endinterface

### hw/rtl/fw_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// fw_packet_deframer_top
// Firmware update packet deframer: bytes in, addressed flash words out.
// ----------------------------------------------------------------------------
// The input channel carries one received byte per beat. Packets are a command
// byte, a length byte and the data bytes. The output channel carries one
// result per beat: a packed 16-bit word with its flash word address, the
// packet end flags, or both.
// One input beat is taken per cycle unless a held result stalls the input. A
// byte that causes a result shows it on the output in the cycle after it is
// accepted; bytes that cause no result only update the framing state.
// The configuration port writes the command code, full length marker and flash
// base address; writing the base also reloads the running packet address. The
// user must make writes only while no packet is in progress; the block does
// not enforce this. Reset returns the deframer to waiting for a command byte
// and loads the register reset values. When the receiver stalls, the result
// register holds its beat; input is ready only while the held beat is taken.
// ----------------------------------------------------------------------------
module fw_packet_deframer_top #(
  parameter int unsigned FULL_WORDS = fwpd_pkg::FULL_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fwpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fwpd_pkg::CFG_W-1:0]       cfg_wdata,
  fwpd_in_if.sink                          in_bus,
  fwpd_out_if.source                       out_bus
);

  logic [fwpd_pkg::BYTE_W-1:0] write_code_r;
  logic [fwpd_pkg::BYTE_W-1:0] full_marker_r;
  logic [fwpd_pkg::ADDR_W-1:0] base_addr_r;
  fwpd_pkg::cfg_t              cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_code_r  <= fwpd_pkg::WRITE_CODE_RST;
      full_marker_r <= fwpd_pkg::FULL_MARKER_RST;
      base_addr_r   <= fwpd_pkg::BASE_ADDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fwpd_pkg::REG_WRITE_CODE:  write_code_r  <= cfg_wdata[fwpd_pkg::BYTE_W-1:0];
        fwpd_pkg::REG_FULL_MARKER: full_marker_r <= cfg_wdata[fwpd_pkg::BYTE_W-1:0];
        fwpd_pkg::REG_BASE_ADDR:   base_addr_r   <= cfg_wdata[fwpd_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.write_command_code = write_code_r;
    cfg.full_length_marker = full_marker_r;
    cfg.base_load          = rst_n && cfg_we && (cfg_index == fwpd_pkg::REG_BASE_ADDR);
    cfg.flash_base_address = cfg.base_load ? cfg_wdata[fwpd_pkg::ADDR_W-1:0] : base_addr_r;
  end

  fwpd_core #(
    .FULL_WORDS (FULL_WORDS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

endmodule

### hw/rtl/fwpd_core.sv
// ----------------------------------------------------------------------------
// fwpd_core
// Packet framing state, word packing, address generation and result register.
// ----------------------------------------------------------------------------
module fwpd_core #(
  parameter int unsigned FULL_WORDS = fwpd_pkg::FULL_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fwpd_pkg::cfg_t      cfg,
  fwpd_in_if.sink             in_bus,
  fwpd_out_if.source          out_bus
);

  localparam int unsigned FULL_BYTES = 2 * FULL_WORDS;
  localparam int unsigned CNT_W      = $clog2(FULL_BYTES + 1);

  fwpd_pkg::phase_t                phase_r, phase_nxt;
  logic [fwpd_pkg::BYTE_W-1:0]     command_r, command_nxt;
  logic                            is_full_r, is_full_nxt;
  logic [CNT_W-1:0]                expected_r, expected_nxt;
  logic [CNT_W-1:0]                received_r, received_nxt;
  logic [fwpd_pkg::BYTE_W-1:0]     low_hold_r, low_hold_nxt;
  logic [fwpd_pkg::ADDR_W-1:0]     pkt_addr_r, pkt_addr_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            res_word_valid_r;
  logic [fwpd_pkg::WORD_W-1:0]     res_data_r;
  logic [fwpd_pkg::ADDR_W-1:0]     res_addr_r;
  logic                            res_end_r, res_done_r, res_bad_r;

  logic                            accept;
  logic                            has_res;
  logic                            r_word_valid, r_end, r_done, r_bad;
  logic [fwpd_pkg::WORD_W-1:0]     r_data;
  logic [fwpd_pkg::ADDR_W-1:0]     r_addr;
  logic                            len_full;
  logic [CNT_W-1:0]                len_expected;
  logic                            cmd_bad;
  logic [CNT_W-1:0]                received_inc;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;

  assign cmd_bad      = (command_r != cfg.write_command_code);
  assign len_full     = (in_bus.rx_byte == cfg.full_length_marker);
  assign len_expected = len_full ? CNT_W'(FULL_BYTES) : CNT_W'(in_bus.rx_byte);
  assign received_inc = received_r + CNT_W'(1);

  always_comb begin
    phase_nxt    = phase_r;
    command_nxt  = command_r;
    is_full_nxt  = is_full_r;
    expected_nxt = expected_r;
    received_nxt = received_r;
    low_hold_nxt = low_hold_r;
    pkt_addr_nxt = pkt_addr_r;
    has_res      = 1'b0;
    r_word_valid = 1'b0;
    r_data       = '0;
    r_addr       = '0;
    r_end        = 1'b0;
    r_done       = 1'b0;
    r_bad        = 1'b0;
    if (accept) begin
      unique case (phase_r)
        fwpd_pkg::PH_CMD: begin
          command_nxt = in_bus.rx_byte;
          phase_nxt   = fwpd_pkg::PH_LEN;
        end
        fwpd_pkg::PH_LEN: begin
          is_full_nxt  = len_full;
          expected_nxt = len_expected;
          received_nxt = '0;
          if (len_expected == '0) begin
            has_res   = 1'b1;
            r_end     = 1'b1;
            r_bad     = cmd_bad;
            r_done    = !cmd_bad && !len_full;
            phase_nxt = fwpd_pkg::PH_CMD;
            if (cmd_bad || !len_full) begin
              pkt_addr_nxt = cfg.flash_base_address;
            end else begin
              pkt_addr_nxt = pkt_addr_r + fwpd_pkg::ADDR_W'(FULL_WORDS);
            end
          end else begin
            phase_nxt = fwpd_pkg::PH_DATA;
          end
        end
        fwpd_pkg::PH_DATA: begin
          r_word_valid = !cmd_bad && received_r[0];
          r_data       = {in_bus.rx_byte, low_hold_r};
          r_addr       = pkt_addr_r + fwpd_pkg::ADDR_W'(received_r >> 1);
          if (!received_r[0]) begin
            low_hold_nxt = in_bus.rx_byte;
          end
          received_nxt = received_inc;
          if (received_inc >= expected_r) begin
            has_res   = 1'b1;
            r_end     = 1'b1;
            r_bad     = cmd_bad;
            r_done    = !cmd_bad && !is_full_r;
            phase_nxt = fwpd_pkg::PH_CMD;
            if (cmd_bad || !is_full_r) begin
              pkt_addr_nxt = cfg.flash_base_address;
            end else begin
              pkt_addr_nxt = pkt_addr_r + fwpd_pkg::ADDR_W'(FULL_WORDS);
            end
          end else begin
            has_res = r_word_valid;
          end
        end
        default: begin
          phase_nxt = fwpd_pkg::PH_CMD;
        end
      endcase
    end
    if (cfg.base_load) begin
      pkt_addr_nxt = cfg.flash_base_address;
    end
    if (!r_word_valid) begin
      r_data = '0;
      r_addr = '0;
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = has_res;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fwpd_pkg::PH_CMD;
      command_r   <= '0;
      is_full_r   <= 1'b0;
      expected_r  <= '0;
      received_r  <= '0;
      low_hold_r  <= '0;
      pkt_addr_r  <= fwpd_pkg::BASE_ADDR_RST;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      command_r   <= command_nxt;
      is_full_r   <= is_full_nxt;
      expected_r  <= expected_nxt;
      received_r  <= received_nxt;
      low_hold_r  <= low_hold_nxt;
      pkt_addr_r  <= pkt_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_res) begin
      res_word_valid_r <= r_word_valid;
      res_data_r       <= r_data;
      res_addr_r       <= r_addr;
      res_end_r        <= r_end;
      res_done_r       <= r_done;
      res_bad_r        <= r_bad;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.word_valid   = res_word_valid_r;
  assign out_bus.data_word    = res_data_r;
  assign out_bus.word_address = res_addr_r;
  assign out_bus.packet_end   = res_end_r;
  assign out_bus.update_done  = res_done_r;
  assign out_bus.bad_command  = res_bad_r;

endmodule

### dv/fw_packet_deframer_top_test.sv
// ----------------------------------------------------------------------------
// fw_packet_deframer_top_test
// Self-checking test of the firmware packet deframer.
// ----------------------------------------------------------------------------
// Bytes are sent as command, length and data packets through the input
// channel. Some packets use a bad command code and some are truncated or
// preceded by stray bytes. A ledger object follows the framing state. For
// every accepted byte it works out any flash word beat that should come out,
// and it compares each output beat, field by field, with the oldest one it
// is waiting for. Both channel sides idle at random, except during one long
// stretch without gaps. The registers move through several settings between
// packets: the reset values, both ends of each range, a zero full-length
// marker, bases that wrap the address, and random values. The spare register
// index is written as well.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fw_packet_deframer_top_test;
  import fwpd_pkg::*;

  localparam int unsigned FULL_WORDS    = FULL_WORDS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned IDLE_PCT      = 36;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 100000;

  typedef struct packed {
    logic              word_valid;
    logic [WORD_W-1:0] data_word;
    logic [ADDR_W-1:0] word_address;
    logic              packet_end;
    logic              update_done;
    logic              bad_command;
  } flash_beat_t;

  class flash_word_ledger;
    int unsigned       full_words;
    logic [BYTE_W-1:0] write_code;
    logic [BYTE_W-1:0] full_marker;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] pkt_addr;
    phase_t            phase;
    logic [BYTE_W-1:0] pkt_cmd;
    logic [BYTE_W-1:0] low_hold;
    bit                pkt_full;
    int unsigned       bytes_due;
    int unsigned       bytes_seen;
    int unsigned       beats_checked;
    flash_beat_t       awaited_words[$];

    function new(int unsigned fw);
      full_words    = fw;
      write_code    = WRITE_CODE_RST;
      full_marker   = FULL_MARKER_RST;
      base_addr     = BASE_ADDR_RST;
      pkt_addr      = BASE_ADDR_RST;
      phase         = PH_CMD;
      pkt_cmd       = '0;
      low_hold      = '0;
      pkt_full      = 1'b0;
      bytes_due     = 0;
      bytes_seen    = 0;
      beats_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_WRITE_CODE:  write_code  = data[BYTE_W-1:0];
        REG_FULL_MARKER: full_marker = data[BYTE_W-1:0];
        REG_BASE_ADDR: begin
          base_addr = data[ADDR_W-1:0];
          pkt_addr  = data[ADDR_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function void close_packet(flash_beat_t beat);
      bit bad;
      bad              = (pkt_cmd != write_code);
      beat.packet_end  = 1'b1;
      beat.bad_command = bad;
      beat.update_done = !bad && !pkt_full;
      awaited_words.push_back(beat);
      if (bad || !pkt_full) begin
        pkt_addr = base_addr;
      end else begin
        pkt_addr = pkt_addr + ADDR_W'(full_words);
      end
      phase = PH_CMD;
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      flash_beat_t beat;
      bit          odd;
      beat = '0;
      case (phase)
        PH_CMD: begin
          pkt_cmd = b;
          phase   = PH_LEN;
        end
        PH_LEN: begin
          pkt_full   = (b == full_marker);
          bytes_due  = pkt_full ? 2 * full_words : int'(b);
          bytes_seen = 0;
          if (bytes_due == 0) begin
            close_packet(beat);
          end else begin
            phase = PH_DATA;
          end
        end
        default: begin
          odd = (bytes_seen % 2) != 0;
          if (odd && pkt_cmd == write_code) begin
            beat.word_valid   = 1'b1;
            beat.data_word    = {b, low_hold};
            beat.word_address = pkt_addr + ADDR_W'(bytes_seen / 2);
          end
          if (!odd) begin
            low_hold = b;
          end
          bytes_seen++;
          if (bytes_seen >= bytes_due) begin
            close_packet(beat);
          end else if (beat.word_valid) begin
            awaited_words.push_back(beat);
          end
        end
      endcase
    endfunction

    function string beat_text(flash_beat_t t);
      return $sformatf("valid=%0b word=%h addr=%h end=%0b done=%0b bad=%0b", t.word_valid,
                       t.data_word, t.word_address, t.packet_end, t.update_done, t.bad_command);
    endfunction

    function bit match_word(flash_beat_t got, output string why);
      flash_beat_t want;
      string       wrong;
      why   = "";
      wrong = "";
      if (awaited_words.size() == 0) begin
        why = {"output beat with nothing awaited: ", beat_text(got)};
        return 1'b0;
      end
      want = awaited_words.pop_front();
      beats_checked++;
      if (got.word_valid !== want.word_valid) wrong = {wrong, " word_valid"};
      if (got.data_word !== want.data_word) wrong = {wrong, " data_word"};
      if (got.word_address !== want.word_address) wrong = {wrong, " word_address"};
      if (got.packet_end !== want.packet_end) wrong = {wrong, " packet_end"};
      if (got.update_done !== want.update_done) wrong = {wrong, " update_done"};
      if (got.bad_command !== want.bad_command) wrong = {wrong, " bad_command"};
      if (wrong == "") begin
        return 1'b1;
      end
      why = $sformatf("beat %0d bad%s: got %s, want %s", beats_checked, wrong,
                      beat_text(got), beat_text(want));
      return 1'b0;
    endfunction

    function bit mid_packet();
      return phase != PH_CMD;
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  fwpd_in_if  in_ch ();
  fwpd_out_if out_ch ();

  flash_word_ledger ledger;
  bit               quiet = 1'b0;
  int unsigned      cycles = 0;
  int unsigned      mismatches = 0;
  int unsigned      bytes_sent = 0;
  int unsigned      packets_sent = 0;
  int unsigned      full_packets = 0;
  int unsigned      bad_packets = 0;
  int unsigned      settings_used = 1;
  logic [7:0]       directed_bytes [0:22];

  fw_packet_deframer_top #(
    .FULL_WORDS(FULL_WORDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_bus   (in_ch),
    .out_bus  (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[cycle %0d] mismatch: %s", cycles, what);
  endtask

  always @(posedge clk) begin : sample
    flash_beat_t got;
    string       why;
    cycles <= cycles + 1;
    if (rst_n === 1'b1) begin
      if (in_ch.valid && in_ch.ready) begin
        ledger.take_byte(in_ch.rx_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.word_valid, out_ch.data_word, out_ch.word_address,
               out_ch.packet_end, out_ch.update_done, out_ch.bad_command};
        if (!ledger.match_word(got, why)) begin
          report_mismatch(why);
        end
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped at the cycle limit with %0d beats still awaited.",
             ledger.awaited_words.size());
    $display("fw_packet_deframer_top_test: FAIL");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_len();
    int unsigned r;
    logic [7:0]  len;
    r = $urandom_range(99);
    if (r < 78) begin
      len = 8'($urandom_range(9));
    end else if (r < 98) begin
      len = 8'($urandom_range(40, 10));
    end else begin
      len = 8'($urandom_range(255));
    end
    if (len == ledger.full_marker) begin
      len = len + 8'd1;
    end
    return len;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] cmd, input logic [7:0] len, input int cut);
    int n;
    n = (len == ledger.full_marker) ? 2 * FULL_WORDS : int'(len);
    packets_sent++;
    if (len == ledger.full_marker) full_packets++;
    if (cmd != ledger.write_code) bad_packets++;
    send_byte(cmd);
    send_byte(len);
    for (int i = 0; i < n && i != cut; i++) begin
      send_byte(rand_byte());
    end
  endtask

  task automatic drain_packet();
    while (ledger.mid_packet()) send_byte(rand_byte());
  endtask

  task automatic run_traffic(input int unsigned target, input int unsigned bad_pct,
                             input int unsigned broken_pct);
    int unsigned start;
    logic [7:0]  cmd;
    logic [7:0]  len;
    int          cut;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      if ($urandom_range(99) < broken_pct) begin
        repeat ($urandom_range(3, 1)) send_byte(rand_byte());
        drain_packet();
      end
      cmd = ledger.write_code;
      if ($urandom_range(99) < bad_pct) begin
        cmd = ledger.write_code ^ 8'($urandom_range(255, 1));
      end
      len = pick_len();
      cut = -1;
      if ($urandom_range(99) < broken_pct) begin
        cut = $urandom_range(int'(len));
      end
      send_packet(cmd, len, cut);
      if (cut >= 0) begin
        send_byte(ledger.write_code);
        send_byte(pick_len());
      end
      drain_packet();
    end
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (ledger.awaited_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    ledger.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] code, input logic [7:0] marker,
                                input logic [31:0] base, input bit with_spare);
    settle();
    cfg_write(REG_WRITE_CODE, CFG_W'(code));
    cfg_write(REG_FULL_MARKER, CFG_W'(marker));
    cfg_write(REG_BASE_ADDR, CFG_W'(base));
    if (with_spare) begin
      cfg_write(REG_SPARE, CFG_W'($urandom));
    end
    cfg_we = 1'b0;
    settings_used++;
  endtask

  initial begin
    ledger        = new(FULL_WORDS);
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_WRITE_CODE;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;

    // Zero length, one dropped byte, a word that closes the packet, bad
    // commands with and without data, and an odd packet with extreme bytes.
    directed_bytes = '{8'h00, 8'h00,
                       8'h00, 8'h01, 8'hFF,
                       8'h00, 8'h02, 8'h00, 8'hFF,
                       8'hFF, 8'h03, 8'h12, 8'h34, 8'h56,
                       8'h01, 8'h00,
                       8'h00, 8'h05, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80};

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    run_traffic(15, 20, 5);

    // With a zero marker a zero length byte means a full packet. The base
    // sits near the top so the word addresses wrap.
    apply_settings(8'hFF, 8'h00, 32'hFFFF_FFC0, 1'b0);
    send_packet(8'hFF, 8'h00, -1);
    run_traffic(15, 20, 5);

    apply_settings(8'($urandom), 8'($urandom), $urandom, 1'b1);
    run_traffic(20, 25, 5);

    apply_settings(8'h00, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_packet(8'h3C, 8'hFF, -1);
    run_traffic(15, 20, 5);

    repeat (3) begin
      apply_settings(8'($urandom), 8'($urandom), $urandom, 1'b1);
      run_traffic(10, 20, 5);
    end

    apply_settings(8'hA5, 8'h01, $urandom, 1'b0);
    quiet = 1'b1;
    run_traffic(40, 15, 0);
    settle();

    $display("Sent %0d bytes: %0d framed packets, %0d full, %0d with a bad command.",
             bytes_sent, packets_sent, full_packets, bad_packets);
    $display("Checked %0d output beats over %0d register settings, %0d mismatches.",
             ledger.beats_checked, settings_used, mismatches);
    if (mismatches == 0) begin
      $display("fw_packet_deframer_top_test: PASS");
    end else begin
      $display("fw_packet_deframer_top_test: FAIL");
    end
    $finish;
  end

endmodule
